### rtl/tod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tod_pkg
// Shared types and constants for the time-of-day clock with zone toggle.
// ----------------------------------------------------------------------------
package tod_pkg;

    // Item operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Day step codes reported by a zone toggle
    localparam logic [1:0] DAY_NONE = 2'd0;
    localparam logic [1:0] DAY_NEXT = 2'd1;
    localparam logic [1:0] DAY_PREV = 2'd2;

    // Register indexes on the APB port (byte address = 4 * index)
    localparam int unsigned   REG_IDX_W       = 2;
    localparam int unsigned   APB_ADDR_W      = REG_IDX_W + 2;
    localparam int unsigned   APB_DATA_W      = 32;
    localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_SEC = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LED_ON_TICKS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ZONE_SHIFT    = 2'd2;

    // Register reset values
    localparam logic [6:0] TICKS_PER_SEC_RST = 7'd100;
    localparam logic [6:0] LED_ON_TICKS_RST  = 7'd20;
    localparam logic [4:0] ZONE_SHIFT_RST    = 5'd6;

    // Time constants
    localparam logic [6:0]  SECS_PER_MIN  = 7'd60;
    localparam logic [6:0]  MINS_PER_HOUR = 7'd60;
    localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
    localparam logic [15:0] MS_PER_TICK   = 16'd10;

    typedef struct packed {
        logic       op;
        logic       button_pin;
        logic [4:0] set_hours;
        logic [5:0] set_minutes;
        logic [5:0] set_seconds;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic        alt_zone;
        logic        second_pulse;
        logic        led_on;
        logic [1:0]  day_step;
        logic [15:0] uptime_ms;
    } t_out_item;

    typedef struct packed {
        logic [6:0] ticks_per_second;
        logic [6:0] led_on_ticks;
        logic [4:0] zone_shift_hours;
    } t_cfg;

endpackage

### rtl/tod_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tod_cfg_regs
// APB register file: ticks per second, LED off point, zone shift.
// ----------------------------------------------------------------------------
module tod_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tod_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tod_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tod_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output tod_pkg::t_cfg                     o_cfg
);
    import tod_pkg::*;

    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;
    t_cfg                 r_cfg;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second <= TICKS_PER_SEC_RST;
            r_cfg.led_on_ticks     <= LED_ON_TICKS_RST;
            r_cfg.zone_shift_hours <= ZONE_SHIFT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TICKS_PER_SEC: r_cfg.ticks_per_second <= pwdata[6:0];
                REG_LED_ON_TICKS:  r_cfg.led_on_ticks     <= pwdata[6:0];
                REG_ZONE_SHIFT:    r_cfg.zone_shift_hours <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TICKS_PER_SEC: prdata = {{(APB_DATA_W-7){1'b0}}, r_cfg.ticks_per_second};
            REG_LED_ON_TICKS:  prdata = {{(APB_DATA_W-7){1'b0}}, r_cfg.led_on_ticks};
            REG_ZONE_SHIFT:    prdata = {{(APB_DATA_W-5){1'b0}}, r_cfg.zone_shift_hours};
            default:           prdata = '0;
        endcase
    end

endmodule

### rtl/tod_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tod_update
// Clock state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module tod_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  tod_pkg::t_in_item  i_item,
    input  tod_pkg::t_cfg      i_cfg,
    output tod_pkg::t_out_item o_res
);
    import tod_pkg::*;

    logic [6:0]  r_tick, n_tick;
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hour, n_hour;
    logic        r_zone, n_zone;
    logic        r_last, n_last;
    logic        r_led, n_led;
    logic [15:0] r_uptime, n_uptime;

    logic [7:0]  w_tick_next;
    logic        w_pulse;
    logic [1:0]  w_step;
    logic        w_pressed;
    logic [4:0]  w_shift;
    logic [5:0]  w_hour_sum;
    logic [4:0]  w_hour_z;
    logic [6:0]  w_sec_inc;
    logic [6:0]  w_min_inc;
    logic [5:0]  w_hour_inc;

    // zone shift taken modulo one day
    assign w_shift = (i_cfg.zone_shift_hours >= HOURS_PER_DAY[4:0])
                   ? i_cfg.zone_shift_hours - HOURS_PER_DAY[4:0]
                   : i_cfg.zone_shift_hours;
    assign w_pressed   = ~i_item.button_pin;
    assign w_tick_next = {1'b0, r_tick} + 8'd1;
    assign w_hour_sum  = {1'b0, r_hour} + {1'b0, w_shift};
    assign w_sec_inc   = {1'b0, r_sec} + 7'd1;
    assign w_min_inc   = {1'b0, r_min} + 7'd1;
    assign w_hour_inc  = {1'b0, w_hour_z} + 6'd1;

    always_comb begin
        n_tick   = r_tick;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_zone   = r_zone;
        n_last   = r_last;
        n_led    = r_led;
        n_uptime = r_uptime;
        w_pulse  = 1'b0;
        w_step   = DAY_NONE;
        w_hour_z = r_hour;
        if (i_item.op == OP_SET) begin
            n_hour = i_item.set_hours;
            n_min  = i_item.set_minutes;
            n_sec  = i_item.set_seconds;
            n_tick = '0;
        end else begin
            // prescaler; no LED off test on the tick that completes a second
            if (w_tick_next >= {1'b0, i_cfg.ticks_per_second}) begin
                w_pulse = 1'b1;
                n_tick  = '0;
                n_led   = 1'b1;
            end else begin
                n_tick = w_tick_next[6:0];
                if (w_tick_next[6:0] == i_cfg.led_on_ticks) begin
                    n_led = 1'b0;
                end
            end
            n_uptime = r_uptime + MS_PER_TICK;
            n_last   = w_pressed;
            // zone toggle on a new press
            if (w_pressed && !r_last) begin
                n_zone = ~r_zone;
                if (!r_zone) begin
                    if (r_hour < w_shift) begin
                        w_hour_z = 5'(w_hour_sum + HOURS_PER_DAY - {w_shift, 1'b0});
                        w_step   = DAY_PREV;
                    end else begin
                        w_hour_z = r_hour - w_shift;
                    end
                end else begin
                    if (w_hour_sum > HOURS_PER_DAY - 6'd1) begin
                        w_hour_z = 5'(w_hour_sum - HOURS_PER_DAY);
                        w_step   = DAY_NEXT;
                    end else begin
                        w_hour_z = w_hour_sum[4:0];
                    end
                end
            end
            n_hour = w_hour_z;
            if (w_pulse) begin
                if (w_sec_inc >= SECS_PER_MIN) begin
                    n_sec = '0;
                    if (w_min_inc >= MINS_PER_HOUR) begin
                        n_min  = '0;
                        n_hour = (w_hour_inc >= HOURS_PER_DAY) ? 5'd0 : w_hour_inc[4:0];
                    end else begin
                        n_min = w_min_inc[5:0];
                    end
                end else begin
                    n_sec = w_sec_inc[5:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_sec    <= '0;
            r_min    <= '0;
            r_hour   <= '0;
            r_zone   <= 1'b0;
            r_last   <= 1'b0;
            r_led    <= 1'b0;
            r_uptime <= '0;
        end else if (i_fire) begin
            r_tick   <= n_tick;
            r_sec    <= n_sec;
            r_min    <= n_min;
            r_hour   <= n_hour;
            r_zone   <= n_zone;
            r_last   <= n_last;
            r_led    <= n_led;
            r_uptime <= n_uptime;
        end
    end

    assign o_res.hours        = n_hour;
    assign o_res.minutes      = n_min;
    assign o_res.seconds      = n_sec;
    assign o_res.alt_zone     = n_zone;
    assign o_res.second_pulse = w_pulse;
    assign o_res.led_on       = n_led;
    assign o_res.day_step     = w_step;
    assign o_res.uptime_ms    = n_uptime;

    a_pulse_clears_prescaler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_pulse |=> r_tick == 7'd0)
        else $error("prescaler not cleared after second pulse");

    a_day_step_flips_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (w_step != DAY_NONE) |=> r_zone != $past(r_zone))
        else $error("day step without zone change");

    a_set_no_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.op == OP_SET) |-> !w_pulse && (w_step == DAY_NONE))
        else $error("set item raised an event");

    a_uptime_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.op == OP_TICK) |=> r_uptime == 16'($past(r_uptime) + MS_PER_TICK))
        else $error("uptime did not advance by one tick");

endmodule

### rtl/time_of_day_clock_with_zone_toggle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_clock_with_zone_toggle_core
// Time-of-day clock with 10 ms tick prescaler, status LED, uptime counter
// and a button-driven zone toggle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one tick or
//   set item per transfer. Output channel (o_out_valid / i_out_stall /
//   o_out_data) returns exactly one result per item, in order.
//   An accepted item is held in the input register, is updated against the
//   clock state in a single pass and lands in the result register.
//   Throughput is one item per cycle while the receiver does not stall;
//   the state update between the input and result registers is the only
//   recurrence.
//   When the receiver stalls, the result register holds its item and the
//   input register holds the next; the input side stalls only once both
//   are full.
//   Reset (synchronous, active low) clears the time, prescaler, zone, LED,
//   uptime and both pipeline valids, and loads the register defaults
//   (100 ticks per second, LED off at tick 20, zone shift 6 hours).
//   Write registers over APB only while the block is idle.
// ----------------------------------------------------------------------------
module time_of_day_clock_with_zone_toggle_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tod_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tod_pkg::t_out_item                o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tod_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tod_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tod_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import tod_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item w_res;
    logic      w_advance;
    logic      w_in_xfer;

    // item moves from input register to result register
    assign w_advance   = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall  = r_in_valid & ~w_advance;
    assign w_in_xfer   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    tod_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tod_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !w_advance)
        else $error("result register overwritten while stalled");

    a_held_item_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("pending input item lost");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result not registered after advance");

endmodule
